@@ rtl/atcp_pkg.sv @@
// Shared types and constants for the terminal character processor.
// No dependencies.
`timescale 1ns / 1ps
package atcp_pkg;
	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_CURSOR = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_SCROLL = 2'd3
	} cmd_t;

	// op code handed from the front to the back
	typedef enum logic [2:0] {
		OP_PRINT = 3'd0,
		OP_BEL   = 3'd1,
		OP_BS    = 3'd2,
		OP_LF    = 3'd3,
		OP_FINAL = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic       has_p0;
		logic [15:0] p0;
	} job_t;

	localparam logic [7:0] CH_ESC  = 8'd27;
	localparam logic [7:0] CH_BEL  = 8'd7;
	localparam logic [7:0] CH_BS   = 8'd8;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_LBR  = 8'd91;
	localparam logic [7:0] CH_SEMI = 8'd59;
	localparam logic [7:0] CH_SP   = 8'd32;
	localparam logic [7:0] CFG_COLUMNS = 8'd0;
	localparam logic [7:0] CFG_ROWS    = 8'd1;
endpackage

@@ rtl/atcp_front.sv @@
// Front end: escape/CSI parser, number accumulation, parameter store and SGR walk.
// Depends on atcp_pkg.
`timescale 1ns / 1ps
module atcp_front #(
	parameter int MAX_PARAMS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	output logic               job_valid,
	input  logic               job_ready,
	output atcp_pkg::job_t     job,
	output logic [2:0]         fg,
	output logic [2:0]         bg
);
	localparam int PW = $clog2(MAX_PARAMS);
	localparam int CW = $clog2(MAX_PARAMS + 1);

	typedef enum logic [1:0] {NORMAL, ESCAPE, CSI, SGR} mode_t;
	mode_t mode_q;
	logic        num_valid_q;
	logic [15:0] num_q;
	logic [15:0] pstore [MAX_PARAMS];
	logic [CW-1:0] pcount_q;
	logic [CW-1:0] walk_q;
	logic [2:0] fg_q, bg_q;
	logic        jv_q;
	atcp_pkg::job_t job_q;

	logic acc;
	logic [19:0] num_next;
	logic [15:0] pending;
	logic [15:0] wp;

	assign in_ready  = (mode_q != SGR) && !jv_q;
	assign acc       = in_valid && in_ready;
	assign job_valid = jv_q;
	assign job       = job_q;
	assign fg        = fg_q;
	assign bg        = bg_q;

	always_comb begin
		num_next = num_valid_q ? ({4'd0, num_q} * 20'd10) : 20'd0;
		num_next = num_next + {16'd0, in_byte[3:0] - 4'd0};
	end
	assign pending = num_valid_q ? num_q : 16'd0;
	assign wp = pstore[walk_q[PW-1:0]];

	always_ff @(posedge clk) begin
		if (acc && mode_q == CSI && pcount_q < CW'(MAX_PARAMS)
				&& (in_byte == atcp_pkg::CH_SEMI
				|| (in_byte >= 8'd64 && in_byte <= 8'd126 && num_valid_q)))
			pstore[pcount_q[PW-1:0]] <= pending;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= NORMAL;
			num_valid_q <= 1'b0;
			num_q <= '0;
			pcount_q <= '0;
			walk_q <= '0;
			fg_q <= 3'd7;
			bg_q <= 3'd0;
			jv_q <= 1'b0;
			job_q <= '0;
		end else begin
			if (jv_q && job_ready)
				jv_q <= 1'b0;
			if (mode_q == SGR) begin
				if (walk_q >= pcount_q) begin
					mode_q <= NORMAL;
					pcount_q <= '0;
				end else begin
					if (wp >= 16'd30 && wp <= 16'd37)
						fg_q <= 3'(wp - 16'd30);
					else if (wp >= 16'd40 && wp <= 16'd47)
						bg_q <= 3'(wp - 16'd40);
					walk_q <= walk_q + CW'(1);
				end
			end else if (acc) begin
				unique case (mode_q)
					NORMAL: begin
						if (in_byte == atcp_pkg::CH_ESC) begin
							mode_q <= ESCAPE;
						end else begin
							jv_q <= 1'b1;
							job_q.ch <= in_byte;
							job_q.has_p0 <= 1'b0;
							job_q.p0 <= '0;
							priority if (in_byte == atcp_pkg::CH_BEL)
								job_q.op <= atcp_pkg::OP_BEL;
							else if (in_byte == atcp_pkg::CH_BS)
								job_q.op <= atcp_pkg::OP_BS;
							else if (in_byte == atcp_pkg::CH_LF)
								job_q.op <= atcp_pkg::OP_LF;
							else
								job_q.op <= atcp_pkg::OP_PRINT;
						end
					end
					ESCAPE: begin
						if (in_byte == atcp_pkg::CH_LBR) begin
							mode_q <= CSI;
							num_valid_q <= 1'b0;
							num_q <= '0;
							pcount_q <= '0;
						end else if (in_byte != atcp_pkg::CH_ESC) begin
							mode_q <= NORMAL;
						end
					end
					CSI: begin
						if (in_byte >= 8'd48 && in_byte <= 8'd57) begin
							num_q <= (num_next > 20'd65535) ? 16'hFFFF : num_next[15:0];
							num_valid_q <= 1'b1;
						end else if (in_byte == atcp_pkg::CH_SEMI) begin
							if (pcount_q < CW'(MAX_PARAMS))
								pcount_q <= pcount_q + CW'(1);
							num_valid_q <= 1'b0;
							num_q <= '0;
						end else if (in_byte >= 8'd64 && in_byte <= 8'd126) begin
							num_valid_q <= 1'b0;
							num_q <= '0;
							// every final goes to the executor, which clamps the cursor
							jv_q <= 1'b1;
							job_q.op <= atcp_pkg::OP_FINAL;
							job_q.ch <= in_byte;
							job_q.has_p0 <= (pcount_q != '0) || num_valid_q;
							job_q.p0 <= (pcount_q != '0) ? pstore[0] : pending;
							if (in_byte == 8'd109) begin
								// SGR: walk stored parameters one per cycle
								mode_q <= SGR;
								walk_q <= '0;
								if (num_valid_q && pcount_q < CW'(MAX_PARAMS))
									pcount_q <= pcount_q + CW'(1);
							end else begin
								mode_q <= NORMAL;
								pcount_q <= '0;
							end
						end
					end
					default: mode_q <= NORMAL;
				endcase
			end
		end
	end
endmodule

@@ rtl/atcp_queue.sv @@
// Short FIFO of jobs between parser and executor (colours travel alongside).
// Depends on atcp_pkg.
`timescale 1ns / 1ps
module atcp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  atcp_pkg::job_t wr_job,
	input  logic [5:0]     wr_col,
	output logic           rd_valid,
	input  logic           rd_ready,
	output atcp_pkg::job_t rd_job,
	output logic [5:0]     rd_col
);
	atcp_pkg::job_t mem_job [2];
	logic [5:0] mem_col [2];
	logic [1:0] wp_q, rp_q;

	assign wr_ready = (wp_q - rp_q) != 2'd2;
	assign rd_valid = wp_q != rp_q;
	assign rd_job   = mem_job[rp_q[0]];
	assign rd_col   = mem_col[rp_q[0]];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) begin
			mem_job[wp_q[0]] <= wr_job;
			mem_col[wp_q[0]] <= wr_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_valid && wr_ready)
				wp_q <= wp_q + 2'd1;
			if (rd_valid && rd_ready)
				rp_q <= rp_q + 2'd1;
		end
	end
endmodule

@@ rtl/atcp_back.sv @@
// Back end: cursor tracking and command generation, up to three beats per job.
// Depends on atcp_pkg.
`timescale 1ns / 1ps
module atcp_back #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     cfg_cols,
	input  logic [6:0]     cfg_rows,
	input  logic           job_valid,
	output logic           job_ready,
	input  atcp_pkg::job_t job,
	input  logic [5:0]     colours,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [47:0]    out_data,
	output logic           out_last
);
	typedef enum logic [1:0] {IDLE, SCROLL, CURSOR} state_t;
	state_t st_q;
	logic [8:0] cmax, rmax; // last column and row, clamped
	logic [6:0] ccol_q;
	logic [5:0] crow_q;
	logic ov_q, ol_q;
	logic [47:0] od_q;
	logic [8:0] cc, cr, n, nc, nr, ec, er, sc, sr;
	logic emit_p, emit_c;
	logic [1:0] emit_cmd;
	logic scroll;
	logic [15:0] p;
	logic take;

	always_comb begin
		cmax = (cfg_cols == 8'd0) ? 9'd0 :
			({1'b0, cfg_cols} > 9'(MAX_COLS)) ? 9'(MAX_COLS - 1) : {1'b0, cfg_cols} - 9'd1;
		rmax = (cfg_rows == 7'd0) ? 9'd0 :
			({2'b0, cfg_rows} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS - 1) : {2'b0, cfg_rows} - 9'd1;
		cc = ({2'b0, ccol_q} > cmax) ? cmax : {2'b0, ccol_q};
		cr = ({3'b0, crow_q} > rmax) ? rmax : {3'b0, crow_q};
	end

	function automatic logic [41:0] fields(input logic [1:0] cmd, input logic [8:0] c,
		input logic [8:0] r, input logic [8:0] e_c, input logic [8:0] e_r,
		input logic [7:0] g, input logic [5:0] col);
		// order from bit 0: cmd, col, row, end_col, end_row, glyph, fg, bg
		fields = {col[5:3], col[2:0], g, e_r[5:0], e_c[6:0], r[5:0], c[6:0], cmd};
	endfunction

	assign take = (st_q == IDLE) && job_valid && (!ov_q || out_ready);
	assign job_ready = take;
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_last  = ol_q;

	always_comb begin
		p = job.has_p0 ? job.p0 : 16'd0;
		n = (p == 16'd0) ? 9'd1 : (p > 16'd255) ? 9'd255 : p[8:0];
		nc = cc; nr = cr;
		emit_p = 1'b0; emit_c = 1'b0; scroll = 1'b0;
		sc = '0; sr = '0; ec = '0; er = '0; emit_cmd = atcp_pkg::CMD_CURSOR;
		unique case (job.op)
			atcp_pkg::OP_PRINT, atcp_pkg::OP_BEL, atcp_pkg::OP_BS, atcp_pkg::OP_LF: begin
				emit_c = 1'b1;
				if (job.op == atcp_pkg::OP_BS) begin
					if (cc != 9'd0) nc = cc - 9'd1;
				end else if (job.op == atcp_pkg::OP_LF) begin
					nc = '0; nr = cr + 9'd1;
				end else if (job.op == atcp_pkg::OP_PRINT) begin
					emit_p = 1'b1;
					if (cc == cmax) begin
						nc = '0; nr = cr + 9'd1;
					end else begin
						nc = cc + 9'd1;
					end
				end
				if (nr > rmax) begin
					scroll = 1'b1; nr = rmax;
				end
			end
			default: begin
				priority if (job.ch >= 8'd65 && job.ch <= 8'd70) begin
					emit_c = 1'b1;
					if (job.ch == 8'd65 || job.ch == 8'd70)
						nr = (n >= cr) ? 9'd0 : cr - n;
					else if (job.ch == 8'd66 || job.ch == 8'd69)
						nr = (cr + n > rmax) ? rmax : cr + n;
					else if (job.ch == 8'd67)
						nc = (cc + n > cmax) ? cmax : cc + n;
					else
						nc = (n >= cc) ? 9'd0 : cc - n;
					if (job.ch == 8'd69 || job.ch == 8'd70) nc = '0;
				end else if (job.ch == 8'd71) begin
					emit_c = 1'b1;
					nc = (p <= 16'd1) ? 9'd0 : ((p - 16'd1) > {7'd0, cmax}) ? cmax : 9'(p - 16'd1);
				end else if (job.ch == 8'd74 || job.ch == 8'd75) begin
					emit_p = (p <= 16'd2);
					emit_cmd = atcp_pkg::CMD_CLEAR;
					if (p == 16'd0) begin
						sc = cc; sr = cr; ec = cmax; er = (job.ch == 8'd74) ? rmax : cr;
					end else if (p == 16'd1) begin
						sc = '0; sr = (job.ch == 8'd74) ? 9'd0 : cr; ec = cc; er = cr;
					end else begin
						sc = '0; ec = cmax;
						sr = (job.ch == 8'd74) ? 9'd0 : cr;
						er = (job.ch == 8'd74) ? rmax : cr;
					end
				end else begin
					// other finals only clamp the cursor
					emit_c = 1'b0;
				end
			end
		endcase
	end

	logic [41:0] cur_f;
	assign cur_f = fields(atcp_pkg::CMD_CURSOR, {2'b0, ccol_q}, {3'b0, crow_q}, '0, '0, 8'd0, 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			ccol_q <= '0;
			crow_q <= '0;
			ov_q <= 1'b0;
			ol_q <= 1'b0;
			od_q <= '0;
		end else begin
			unique case (st_q)
				IDLE: if (take) begin
					ccol_q <= nc[6:0];
					crow_q <= nr[5:0];
					if (job.op == atcp_pkg::OP_FINAL && emit_cmd == atcp_pkg::CMD_CLEAR) begin
						ov_q <= emit_p;
						ol_q <= 1'b1;
						od_q <= {6'd0, fields(atcp_pkg::CMD_CLEAR, sc, sr, ec, er,
							atcp_pkg::CH_SP, colours)};
					end else if (emit_p) begin
						ov_q <= 1'b1;
						ol_q <= 1'b0;
						od_q <= {6'd0, fields(atcp_pkg::CMD_WRITE, cc, cr, '0, '0, job.ch, colours)};
						st_q <= scroll ? SCROLL : CURSOR;
					end else if (scroll) begin
						ov_q <= 1'b1;
						ol_q <= 1'b0;
						od_q <= {6'd0, fields(atcp_pkg::CMD_SCROLL, '0, '0, '0, '0,
							atcp_pkg::CH_SP, 6'b000_111)};
						st_q <= CURSOR;
					end else if (emit_c) begin
						ov_q <= 1'b1;
						ol_q <= 1'b1;
						od_q <= {6'd0, fields(atcp_pkg::CMD_CURSOR, nc, nr, '0, '0, 8'd0, 6'd0)};
					end else begin
						ov_q <= 1'b0;
					end
				end else if (ov_q && out_ready) begin
					ov_q <= 1'b0;
				end
				SCROLL: if (!ov_q || out_ready) begin
					ov_q <= 1'b1;
					ol_q <= 1'b0;
					od_q <= {6'd0, fields(atcp_pkg::CMD_SCROLL, '0, '0, '0, '0,
						atcp_pkg::CH_SP, 6'b000_111)};
					st_q <= CURSOR;
				end
				CURSOR: if (!ov_q || out_ready) begin
					ov_q <= 1'b1;
					ol_q <= 1'b1;
					od_q <= {6'd0, cur_f};
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

@@ rtl/ansi_terminal_char_processor_top.sv @@
// Top level of the terminal character processor: config registers, parser, queue, executor.
// Depends on atcp_pkg, atcp_front, atcp_queue, atcp_back.
`timescale 1ns / 1ps
// Takes one terminal byte a beat and emits display commands (write cell, set cursor,
// clear span, scroll). A printable byte costs up to three output beats, one per cycle
// while the output is ready; ESC, CSI digits and separators are taken without holding
// the parser. A byte that makes a job (printable, BEL, BS, LF or a CSI final) holds the
// parser until the job moves into the queue. An SGR final byte walks its stored
// parameters one per cycle, so it occupies the parser until the walk is done. A queue
// of two jobs sits between parser and executor, so the parser can run ahead of it; a
// printable byte is bound by the executor's two or three command beats.
module ansi_terminal_char_processor_top #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	parameter int MAX_PARAMS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // byte_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // command, col, row, end_col, end_row, glyph, fg, bg
	output logic        m_axis_tlast
);
	logic [7:0] cols_q;
	logic [6:0] rows_q;
	logic fv, fr, qv, qr;
	atcp_pkg::job_t fjob, qjob;
	logic [2:0] fg, bg;
	logic [5:0] qcol;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 8'd80;
			rows_q <= 7'd25;
		end else if (cfg_we) begin
			if (cfg_index == atcp_pkg::CFG_COLUMNS) cols_q <= cfg_data;
			else if (cfg_index == atcp_pkg::CFG_ROWS) rows_q <= cfg_data[6:0];
		end
	end

	atcp_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_byte(s_axis_tdata),
		.job_valid(fv), .job_ready(fr), .job(fjob), .fg(fg), .bg(bg)
	);

	atcp_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fv), .wr_ready(fr), .wr_job(fjob), .wr_col({bg, fg}),
		.rd_valid(qv), .rd_ready(qr), .rd_job(qjob), .rd_col(qcol)
	);

	atcp_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
		.clk, .arst_n, .cfg_cols(cols_q), .cfg_rows(rows_q),
		.job_valid(qv), .job_ready(qr), .job(qjob), .colours(qcol),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_last(m_axis_tlast)
	);
endmodule

@@ bench/testbench.sv @@
// Self-checking bench for ansi_terminal_char_processor_top: directed table, then random
// byte streams of escape sequences, printables and noise, checked against a local predictor.
// Depends on atcp_pkg and the RTL of the block.
`timescale 1ns / 1ps
module testbench;
	typedef enum int {PM_NORMAL, PM_ESCAPE, PM_CSI} parse_mode_t;

	typedef struct {
		atcp_pkg::cmd_t cmd;
		logic [6:0] col;
		logic [5:0] row;
		logic [6:0] end_col;
		logic [5:0] end_row;
		logic [7:0] glyph;
		logic [2:0] fg;
		logic [2:0] bg;
		logic       last;
	} disp_cmd_t;

	typedef struct {
		logic [7:0] b;
		int         n_typed;   // hand-typed expectations, -1 means use the predictor
	} stim_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [7:0]  cfg_index = 0;
	logic [7:0]  cfg_data = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 0;   // byte_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [47:0] m_axis_tdata;       // command, col, row, end_col, end_row, glyph, fg, bg
	logic        m_axis_tlast;

	ansi_terminal_char_processor_top dut (.*);

	always #5 clk = ~clk;

	// predictor state
	int          n_cols = 80, n_rows = 25;
	parse_mode_t pmode = PM_NORMAL;
	int          cur_col = 0, cur_row = 0;
	bit          num_valid = 0;
	int          num_accum = 0;
	int          params [8];
	int          param_cnt = 0;
	logic [2:0]  fg_cur = 3'd7, bg_cur = 3'd0;

	disp_cmd_t   disp_q [$];
	stim_row_t   dir_tab [$];
	int          errors = 0;
	int          bytes_sent = 0;
	int          tx_idle = 0, rx_idle = 0;
	int          quiet_cycles = 0;

	function automatic disp_cmd_t mk_cmd(atcp_pkg::cmd_t c, int x, int y, int ex, int ey,
			int g, int f, int bk);
		disp_cmd_t d;
		d.cmd = c; d.col = 7'(x); d.row = 6'(y); d.end_col = 7'(ex); d.end_row = 6'(ey);
		d.glyph = 8'(g); d.fg = 3'(f); d.bg = 3'(bk); d.last = 0;
		return d;
	endfunction

	task automatic add_cmd(ref disp_cmd_t q [$], input disp_cmd_t d);
		q.insert(q.size(), d);
	endtask

	task automatic add_row(logic [7:0] b, int n_typed);
		stim_row_t r;
		r.b = b;
		r.n_typed = n_typed;
		dir_tab.insert(dir_tab.size(), r);
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_row(s[i], -1);
	endtask

	function automatic int eff_cols();
		return (n_cols < 1) ? 1 : (n_cols > 128) ? 128 : n_cols;
	endfunction

	function automatic int eff_rows();
		return (n_rows < 1) ? 1 : (n_rows > 64) ? 64 : n_rows;
	endfunction

	task automatic clamp_cursor();
		if (cur_col > eff_cols() - 1) cur_col = eff_cols() - 1;
		if (cur_row > eff_rows() - 1) cur_row = eff_rows() - 1;
	endtask

	task automatic push_param(int v);
		if (param_cnt < 8) begin
			params[param_cnt] = v;
			param_cnt++;
		end
	endtask

	task automatic run_final(logic [7:0] f, ref disp_cmd_t res [$]);
		int cols, rws, n, sc, sr, ec, er;
		cols = eff_cols();
		rws = eff_rows();
		clamp_cursor();
		if (f >= "A" && f <= "F") begin
			n = (param_cnt > 0) ? params[0] : 1;
			if (n == 0) n = 1;
			if (f == "A" || f == "F")
				cur_row = (n >= cur_row) ? 0 : cur_row - n;
			else if (f == "B" || f == "E")
				cur_row = (cur_row + n > rws - 1) ? rws - 1 : cur_row + n;
			else if (f == "C")
				cur_col = (cur_col + n > cols - 1) ? cols - 1 : cur_col + n;
			else
				cur_col = (n >= cur_col) ? 0 : cur_col - n;
			if (f == "E" || f == "F") cur_col = 0;
			add_cmd(res, mk_cmd(atcp_pkg::CMD_CURSOR, cur_col, cur_row, 0, 0, 0, 0, 0));
		end else if (f == "G") begin
			n = (param_cnt > 0) ? params[0] : 0;
			n = (n == 0) ? 0 : n - 1;
			cur_col = (n > cols - 1) ? cols - 1 : n;
			add_cmd(res, mk_cmd(atcp_pkg::CMD_CURSOR, cur_col, cur_row, 0, 0, 0, 0, 0));
		end else if (f == "J" || f == "K") begin
			n = (param_cnt > 0) ? params[0] : 0;
			if (n <= 2) begin
				if (n == 0) begin
					sc = cur_col; sr = cur_row; ec = cols - 1;
					er = (f == "J") ? rws - 1 : cur_row;
				end else if (n == 1) begin
					sc = 0; sr = (f == "J") ? 0 : cur_row;
					ec = cur_col; er = cur_row;
				end else begin
					sc = 0; ec = cols - 1;
					sr = (f == "J") ? 0 : cur_row;
					er = (f == "J") ? rws - 1 : cur_row;
				end
				add_cmd(res, mk_cmd(atcp_pkg::CMD_CLEAR, sc, sr, ec, er, atcp_pkg::CH_SP,
					fg_cur, bg_cur));
			end
		end else if (f == "m") begin
			for (int i = 0; i < param_cnt; i++) begin
				if (params[i] >= 30 && params[i] <= 37) fg_cur = 3'(params[i] - 30);
				else if (params[i] >= 40 && params[i] <= 47) bg_cur = 3'(params[i] - 40);
			end
		end
	endtask

	// advances the predictor by one byte and returns the display commands it causes
	task automatic predict_byte(logic [7:0] b, ref disp_cmd_t res [$]);
		int v;
		res = {};
		case (pmode)
			PM_NORMAL: begin
				if (b == atcp_pkg::CH_ESC) begin
					pmode = PM_ESCAPE;
				end else begin
					clamp_cursor();
					if (b == atcp_pkg::CH_BEL) begin
					end else if (b == atcp_pkg::CH_BS) begin
						if (cur_col > 0) cur_col--;
					end else if (b == atcp_pkg::CH_LF) begin
						cur_row++;
						cur_col = 0;
					end else begin
						add_cmd(res, mk_cmd(atcp_pkg::CMD_WRITE, cur_col, cur_row, 0, 0, b,
							fg_cur, bg_cur));
						cur_col++;
						if (cur_col >= eff_cols()) begin
							cur_col = 0;
							cur_row++;
						end
					end
					if (cur_row >= eff_rows()) begin
						add_cmd(res, mk_cmd(atcp_pkg::CMD_SCROLL, 0, 0, 0, 0, atcp_pkg::CH_SP,
							7, 0));
						cur_row = eff_rows() - 1;
					end
					add_cmd(res, mk_cmd(atcp_pkg::CMD_CURSOR, cur_col, cur_row, 0, 0, 0, 0, 0));
				end
			end
			PM_ESCAPE: begin
				if (b == atcp_pkg::CH_LBR) begin
					pmode = PM_CSI;
					num_valid = 0;
					num_accum = 0;
					param_cnt = 0;
				end else if (b != atcp_pkg::CH_ESC) begin
					pmode = PM_NORMAL;
				end
			end
			default: begin
				if (b >= "0" && b <= "9") begin
					v = num_valid ? num_accum * 10 + (b - "0") : (b - "0");
					num_accum = (v > 65535) ? 65535 : v;
					num_valid = 1;
				end else if (b == atcp_pkg::CH_SEMI) begin
					push_param(num_valid ? num_accum : 0);
					num_valid = 0;
					num_accum = 0;
				end else if (b >= 64 && b <= 126) begin
					if (num_valid) push_param(num_accum);
					num_valid = 0;
					num_accum = 0;
					run_final(b, res);
					param_cnt = 0;
					pmode = PM_NORMAL;
				end
			end
		endcase
		if (res.size() > 0) res[res.size() - 1].last = 1;
	endtask

	task automatic send_byte(logic [7:0] b, int n_typed = -1);
		disp_cmd_t res [$];
		predict_byte(b, res);
		if (n_typed >= 0) res = typed_q;
		foreach (res[i]) add_cmd(disp_q, res[i]);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	// hand-typed expectations for the current directed row
	disp_cmd_t   typed_q [$];

	// waits for every expected beat, then for the executor and any SGR walk to settle
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (disp_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == atcp_pkg::CFG_COLUMNS) n_cols = val;
		else n_rows = val[6:0];
	endtask

	task automatic send_number(int v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// one random chunk of the stream: mostly well-formed CSI sequences and text
	task automatic random_chunk();
		string finals;
		int kind, np;
		finals = "ABCDEFGJKm";
		kind = $urandom_range(99);
		if (kind < 45) begin
			send_byte(atcp_pkg::CH_ESC);
			if ($urandom_range(9) == 0) send_byte(atcp_pkg::CH_ESC);
			send_byte(atcp_pkg::CH_LBR);
			np = ($urandom_range(4) == 0) ? $urandom_range(11) : $urandom_range(2);
			for (int i = 0; i < np; i++) begin
				case ($urandom_range(5))
					0: ;
					1: send_number($urandom_range(99999));
					2: send_number($urandom_range(47, 30));
					3: send_number($urandom_range(3));
					default: send_number($urandom_range(140));
				endcase
				if ($urandom_range(15) == 0) send_byte(8'($urandom_range(63, 32)));
				if (i < np - 1) send_byte(atcp_pkg::CH_SEMI);
			end
			if ($urandom_range(7) == 0) send_byte(8'($urandom_range(126, 64)));
			else send_byte(finals[$urandom_range(finals.len() - 1)]);
		end else if (kind < 75) begin
			send_byte(8'($urandom_range(126, 32)));
		end else if (kind < 87) begin
			case ($urandom_range(2))
				0: send_byte(atcp_pkg::CH_BEL);
				1: send_byte(atcp_pkg::CH_BS);
				default: send_byte(atcp_pkg::CH_LF);
			endcase
		end else if (kind < 93) begin
			send_byte(atcp_pkg::CH_ESC);
			send_byte(8'($urandom_range(255)));
		end else begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= rx_idle);

	always @(posedge clk) begin
		disp_cmd_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (disp_q.size() == 0) begin
				$error("unexpected beat %h", m_axis_tdata);
				errors++;
			end else begin
				e = disp_q.pop_front();
				if (m_axis_tdata[1:0] != e.cmd) begin
					$error("command exp %0d got %0d", e.cmd, m_axis_tdata[1:0]); errors++;
				end
				if (m_axis_tdata[8:2] != e.col) begin
					$error("col exp %0d got %0d", e.col, m_axis_tdata[8:2]); errors++;
				end
				if (m_axis_tdata[14:9] != e.row) begin
					$error("row exp %0d got %0d", e.row, m_axis_tdata[14:9]); errors++;
				end
				if (m_axis_tdata[21:15] != e.end_col) begin
					$error("end_col exp %0d got %0d", e.end_col, m_axis_tdata[21:15]);
					errors++;
				end
				if (m_axis_tdata[27:22] != e.end_row) begin
					$error("end_row exp %0d got %0d", e.end_row, m_axis_tdata[27:22]);
					errors++;
				end
				if (m_axis_tdata[35:28] != e.glyph) begin
					$error("glyph exp %0d got %0d", e.glyph, m_axis_tdata[35:28]); errors++;
				end
				if (m_axis_tdata[38:36] != e.fg) begin
					$error("fg_color exp %0d got %0d", e.fg, m_axis_tdata[38:36]); errors++;
				end
				if (m_axis_tdata[41:39] != e.bg) begin
					$error("bg_color exp %0d got %0d", e.bg, m_axis_tdata[41:39]); errors++;
				end
				if (m_axis_tlast != e.last) begin
					$error("last exp %0d got %0d", e.last, m_axis_tlast); errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == 20000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		add_row("A", 2);
		add_row(atcp_pkg::CH_BEL, -1);
		add_row(atcp_pkg::CH_BS, -1);
		add_row(atcp_pkg::CH_BS, -1);
		add_row(atcp_pkg::CH_LF, -1);
		add_row(8'd255, -1);
		add_row(8'd0, -1);
		add_row(atcp_pkg::CH_ESC, -1);
		add_text("[999999C");
		add_row(atcp_pkg::CH_ESC, -1);
		add_text("[31;44m");
		add_row(atcp_pkg::CH_ESC, -1);
		add_text("[m");
		add_row(atcp_pkg::CH_ESC, -1);
		add_text("[2J");

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, default size 80 x 25
		foreach (dir_tab[i]) begin
			typed_q = {};
			if (i == 0) begin
				add_cmd(typed_q, mk_cmd(atcp_pkg::CMD_WRITE, 0, 0, 0, 0, "A", 7, 0));
				add_cmd(typed_q, mk_cmd(atcp_pkg::CMD_CURSOR, 1, 0, 0, 0, 0, 0, 0));
				typed_q[1].last = 1;
			end
			send_byte(dir_tab[i].b, dir_tab[i].n_typed);
		end
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle = 33; rx_idle = 72;
					write_reg(atcp_pkg::CFG_COLUMNS, 8'd1);
					write_reg(atcp_pkg::CFG_ROWS, 8'd1);
				end
				1: begin
					tx_idle = 72; rx_idle = 33;
					write_reg(atcp_pkg::CFG_COLUMNS, 8'd128);
					write_reg(atcp_pkg::CFG_ROWS, 8'd64);
				end
				default: begin
					tx_idle = 0; rx_idle = 0;
					write_reg(atcp_pkg::CFG_COLUMNS, 8'($urandom_range(12, 2)));
					write_reg(atcp_pkg::CFG_ROWS, 8'($urandom_range(6, 2)));
				end
			endcase
			while (bytes_sent < 40 + (ph + 1) * 140) begin
				random_chunk();
				// shrink the display mid-phase so the cursor gets clamped
				if (ph == 1 && bytes_sent > 120 && n_cols == 128) begin
					drain();
					write_reg(atcp_pkg::CFG_COLUMNS, 8'($urandom_range(40, 3)));
					write_reg(atcp_pkg::CFG_ROWS, 8'($urandom_range(20, 2)));
				end
			end
			drain();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
